// ===== src/ils_pkg.sv =====
package ils_pkg;

  localparam int ValW    = 32;
  localparam int MaxCntW = 11;

  typedef logic [MaxCntW-1:0] cnt_t;

  typedef enum logic [2:0] {
    OP_INSERT       = 3'd0,
    OP_APPEND       = 3'd1,
    OP_REMOVE_FIRST = 3'd2,
    OP_REMOVE_LAST  = 3'd3,
    OP_READ         = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]             operation;
    logic [4:0]             position;
    logic signed [ValW-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [ValW-1:0] result_value;
    logic signed [ValW-1:0] front_value;
    logic signed [ValW-1:0] back_value;
    logic [4:0]             entry_count;
    logic [1:0]             status;
  } rsp_t;

  // shared by every cell; ins/del only pulse on an accepted transfer
  typedef struct packed {
    logic ins;
    logic del;
    cnt_t pos;
    cnt_t rd_idx;
    cnt_t bk_idx;
  } cell_ctrl_t;

endpackage

// ===== src/ils_cell.sv =====
module ils_cell #(
  parameter int IDX = 0
) (
  input  logic                           clk_i,
  input  ils_pkg::cell_ctrl_t            ctrl_i,
  input  logic signed [ils_pkg::ValW-1:0] val_i,
  input  logic signed [ils_pkg::ValW-1:0] left_i,
  input  logic signed [ils_pkg::ValW-1:0] right_i,
  output logic signed [ils_pkg::ValW-1:0] q_o,
  output logic signed [ils_pkg::ValW-1:0] rd_o,
  output logic signed [ils_pkg::ValW-1:0] bk_o
);

  localparam ils_pkg::cnt_t MyIdx = ils_pkg::cnt_t'(IDX);

  logic signed [ils_pkg::ValW-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (MyIdx == ctrl_i.pos) begin
        data_d = val_i;
      end else if (MyIdx > ctrl_i.pos) begin
        data_d = left_i;
      end
    end else if (ctrl_i.del) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign q_o  = data_q;
  assign rd_o = (MyIdx == ctrl_i.rd_idx) ? data_q : '0;
  assign bk_o = (MyIdx == ctrl_i.bk_idx) ? data_q : '0;

endmodule

// ===== src/indexed_list_store.sv =====
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_stall_o  | ils_pkg::req_t in_data_i
// out     | output    | out_valid_o / out_stall_i| ils_pkg::rsp_t out_data_o
//
// One request per cycle sustained while in_stall_o is low; the cell row updates at the accepting edge.
// A result waits in the pending register, then loads into the output register, where front/back are picked.
// rst_ni clears the count and handshake state; cell contents need no reset.
// A stalled output holds one result, one more waits behind it, then in_stall_o rises.
module indexed_list_store #(
  parameter int CAPACITY = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ils_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ils_pkg::rsp_t out_data_o
);

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam ils_pkg::cnt_t Cap = ils_pkg::cnt_t'(CAPACITY);

  logic [CntW-1:0] count_q, count_d;
  logic            pend_valid_q, pend_valid_d;
  logic signed [ils_pkg::ValW-1:0] pend_res_q;
  logic [1:0]      pend_st_q;
  logic            out_valid_q, out_valid_d;
  ils_pkg::rsp_t   out_q;

  logic            accept, out_load;
  ils_pkg::cnt_t   n_ext, pos_ext, n_nxt;
  ils_pkg::cell_ctrl_t ctrl;
  logic            ins, del, res_en;
  ils_pkg::status_e st;

  logic signed [ils_pkg::ValW-1:0] cell_q  [CAPACITY];
  logic signed [ils_pkg::ValW-1:0] cell_rd [CAPACITY];
  logic signed [ils_pkg::ValW-1:0] cell_bk [CAPACITY];
  logic signed [ils_pkg::ValW-1:0] rd_or, bk_or, res_val;
  ils_pkg::cnt_t   cnt_out;

  assign out_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = pend_valid_q && !out_load;
  assign accept     = in_valid_i && !in_stall_o;

  assign n_ext   = ils_pkg::cnt_t'(count_q);
  assign pos_ext = ils_pkg::cnt_t'(in_data_i.position);

  always_comb begin
    ins         = 1'b0;
    del         = 1'b0;
    res_en      = 1'b0;
    st          = ils_pkg::ST_OK;
    n_nxt       = n_ext;
    ctrl.pos    = pos_ext;
    ctrl.rd_idx = pos_ext;
    case (in_data_i.operation)
      ils_pkg::OP_INSERT: begin
        if (pos_ext > n_ext) begin
          st = ils_pkg::ST_BADPOS;
        end else if (n_ext >= Cap) begin
          st = ils_pkg::ST_FULL;
        end else begin
          ins   = 1'b1;
          n_nxt = n_ext + 1'b1;
        end
      end
      ils_pkg::OP_APPEND: begin
        ctrl.pos = n_ext;
        if (n_ext >= Cap) begin
          st = ils_pkg::ST_FULL;
        end else begin
          ins   = 1'b1;
          n_nxt = n_ext + 1'b1;
        end
      end
      ils_pkg::OP_REMOVE_FIRST: begin
        ctrl.rd_idx = '0;
        if (n_ext == '0) begin
          st = ils_pkg::ST_EMPTY;
        end else begin
          del    = 1'b1;
          res_en = 1'b1;
          n_nxt  = n_ext - 1'b1;
        end
      end
      ils_pkg::OP_REMOVE_LAST: begin
        ctrl.rd_idx = n_ext - 1'b1;
        if (n_ext == '0) begin
          st = ils_pkg::ST_EMPTY;
        end else begin
          res_en = 1'b1;
          n_nxt  = n_ext - 1'b1;
        end
      end
      ils_pkg::OP_READ: begin
        if (pos_ext >= n_ext) begin
          st = ils_pkg::ST_BADPOS;
        end else begin
          res_en = 1'b1;
        end
      end
      default: begin
      end
    endcase
    ctrl.ins    = ins && accept;
    ctrl.del    = del && accept;
    // wraps past every cell when empty, so back reads as zero
    ctrl.bk_idx = n_ext - 1'b1;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [ils_pkg::ValW-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = cell_q[i];
    end else begin : g_mid_r
      assign right = cell_q[i+1];
    end
    ils_cell #(.IDX(i)) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .val_i   (in_data_i.value),
      .left_i  (left),
      .right_i (right),
      .q_o     (cell_q[i]),
      .rd_o    (cell_rd[i]),
      .bk_o    (cell_bk[i])
    );
  end

  always_comb begin
    rd_or = '0;
    bk_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | cell_rd[i];
      bk_or = bk_or | cell_bk[i];
    end
  end

  assign res_val = res_en ? rd_or : '0;
  assign cnt_out = n_ext;

  assign count_d      = accept ? n_nxt[CntW-1:0] : count_q;
  assign pend_valid_d = accept ? 1'b1 : (out_load ? 1'b0 : pend_valid_q);
  assign out_valid_d  = out_load ? pend_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      count_q      <= count_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_res_q <= res_val;
      pend_st_q  <= st;
    end
    if (out_load && pend_valid_q) begin
      out_q.result_value <= pend_res_q;
      out_q.front_value  <= (count_q != '0) ? cell_q[0] : '0;
      out_q.back_value   <= bk_or;
      out_q.entry_count  <= cnt_out[4:0];
      out_q.status       <= pend_st_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
